// ----- src/meps_pkg.sv -----
// Package for the mesh edge plane slicer: widths, register indexes, constants.
// Used by the interface file and the top level.
package meps_pkg;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned NORM_W = 18;
  localparam int unsigned EPS_W = 16;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned D_W = 33;
  localparam int unsigned PROD_W = 51;
  localparam int unsigned SUM_W = 53;
  localparam int unsigned MAG_W = 52;
  localparam int unsigned WIDE_W = 85;
  localparam int unsigned QUO_W = 41;
  localparam int unsigned MUL_PIPE = 3;
  localparam int unsigned PIPE_LEN = 6 + MUL_PIPE + WIDE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_ANCHOR_X = 3'd3,
    REG_ANCHOR_Y = 3'd4,
    REG_ANCHOR_Z = 3'd5,
    REG_DENOM_EPS = 3'd6,
    REG_UNUSED = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } edge_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
  } hit_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;
endpackage

// ----- src/meps_if.sv -----
// Valid/ready channel interfaces for edges, hits and register writes.
// Depends on meps_pkg for the payload types.
interface meps_edge_if;
  logic valid;
  logic ready;
  meps_pkg::edge_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface meps_hit_if;
  logic valid;
  logic ready;
  meps_pkg::hit_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface meps_cfg_if;
  logic valid;
  logic ready;
  meps_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/mesh_edge_plane_slicer.sv -----
// Top level of the mesh edge plane slicer: register file, dot products,
// pipelined restoring dividers and saturation. Depends on meps_pkg, meps_if.

// One edge enters per clock while the output is not stalled. The pipeline has
// three stages for the differences, products and sums, three for
// the wide product, 85 restoring divider stages and the output register.
// Each divider stage resolves one quotient bit of the 85-bit dividend in
// each of three lanes. The whole pipeline advances when the output register
// is empty or being read, so a stall holds every stage. Edges that miss the
// slice height or are near parallel to the plane travel as bubbles and give
// no hit. Register writes should be made while no edge is in flight.
module mesh_edge_plane_slicer (
  input logic clk_i,
  input logic rst_ni,
  meps_cfg_if.sink cfg,
  meps_edge_if.sink edge_in,
  meps_hit_if.source hit_out
);
  localparam int unsigned CW = meps_pkg::COORD_W;
  localparam int unsigned DW = meps_pkg::D_W;
  localparam int unsigned SW = meps_pkg::SUM_W;
  localparam int unsigned MW = meps_pkg::MAG_W;
  localparam int unsigned WW = meps_pkg::WIDE_W;
  localparam int unsigned QW = meps_pkg::QUO_W;
  localparam int unsigned DIVN = WW;

  logic signed [meps_pkg::NORM_W-1:0] nrm_q [3];
  logic signed [CW-1:0] anc_q [3];
  logic [meps_pkg::EPS_W-1:0] eps_q;
  logic adv;

  assign cfg.ready = 1'b1;
  assign adv = !hit_out.valid || hit_out.ready;
  assign edge_in.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= meps_pkg::NORM_W'(1 << 16);
      anc_q[0] <= '0;
      anc_q[1] <= '0;
      anc_q[2] <= '0;
      eps_q <= meps_pkg::EPS_W'(1);
    end else if (cfg.valid) begin
      case (meps_pkg::reg_idx_e'(cfg.data.index))
        meps_pkg::REG_NORMAL_X: nrm_q[0] <= cfg.data.data[meps_pkg::NORM_W-1:0];
        meps_pkg::REG_NORMAL_Y: nrm_q[1] <= cfg.data.data[meps_pkg::NORM_W-1:0];
        meps_pkg::REG_NORMAL_Z: nrm_q[2] <= cfg.data.data[meps_pkg::NORM_W-1:0];
        meps_pkg::REG_ANCHOR_X: anc_q[0] <= cfg.data.data;
        meps_pkg::REG_ANCHOR_Y: anc_q[1] <= cfg.data.data;
        meps_pkg::REG_ANCHOR_Z: anc_q[2] <= cfg.data.data;
        meps_pkg::REG_DENOM_EPS: eps_q <= cfg.data.data[meps_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: differences and span check.
  logic v1_q;
  logic signed [CW-1:0] p1_q [3];
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] e1_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= edge_in.valid &&
      !((anc_q[2] < edge_in.data.start_z && anc_q[2] < edge_in.data.end_z) ||
        (anc_q[2] > edge_in.data.start_z && anc_q[2] > edge_in.data.end_z));
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q[0] <= edge_in.data.start_x;
      p1_q[1] <= edge_in.data.start_y;
      p1_q[2] <= edge_in.data.start_z;
      d1_q[0] <= DW'(edge_in.data.start_x) - DW'(edge_in.data.end_x);
      d1_q[1] <= DW'(edge_in.data.start_y) - DW'(edge_in.data.end_y);
      d1_q[2] <= DW'(edge_in.data.start_z) - DW'(edge_in.data.end_z);
      e1_q[0] <= DW'(anc_q[0]) - DW'(edge_in.data.start_x);
      e1_q[1] <= DW'(anc_q[1]) - DW'(edge_in.data.start_y);
      e1_q[2] <= DW'(anc_q[2]) - DW'(edge_in.data.start_z);
    end
  end

  // Stage 2: six products.
  logic v2_q;
  logic signed [CW-1:0] p2_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [meps_pkg::PROD_W-1:0] pd2_q [3];
  logic signed [meps_pkg::PROD_W-1:0] pe2_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p2_q[i] <= p1_q[i];
        d2_q[i] <= d1_q[i];
        pd2_q[i] <= meps_pkg::PROD_W'(nrm_q[i] * d1_q[i]);
        pe2_q[i] <= meps_pkg::PROD_W'(nrm_q[i] * e1_q[i]);
      end
    end
  end

  // Stage 3: sums, epsilon test, magnitudes and signs.
  logic v3_q;
  logic signed [CW-1:0] p3_q [3];
  logic [DW-1:0] dm3_q [3];
  logic [2:0] neg3_q;
  logic [MW-1:0] num3_q, den3_q;
  logic signed [SW-1:0] den_s, num_s;
  logic [MW-1:0] den_m;
  always_comb begin
    den_s = SW'(pd2_q[0]) + SW'(pd2_q[1]) + SW'(pd2_q[2]);
    num_s = SW'(pe2_q[0]) + SW'(pe2_q[1]) + SW'(pe2_q[2]);
    den_m = den_s[SW-1] ? MW'(-den_s) : MW'(den_s);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q && (den_m > MW'(eps_q));
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p3_q[i] <= p2_q[i];
        dm3_q[i] <= d2_q[i][DW-1] ? DW'(-d2_q[i]) : DW'(d2_q[i]);
        neg3_q[i] <= (num_s[SW-1] ^ d2_q[i][DW-1]) ^ den_s[SW-1];
      end
      num3_q <= num_s[SW-1] ? MW'(-num_s) : MW'(num_s);
      den3_q <= den_m;
    end
  end

  // Stages 4 to 6: 52x33 magnitude product split into partial products.
  logic v4_q, v5_q, v6_q;
  logic signed [CW-1:0] p4_q [3], p5_q [3], p6_q [3];
  logic [2:0] neg4_q, neg5_q, neg6_q;
  logic [MW-1:0] den4_q, den5_q, den6_q;
  logic [WW-1:0] lo4_q [3], hi4_q [3], lo5_q [3], prod6_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        lo4_q[i] <= WW'(num3_q[25:0] * dm3_q[i]);
        hi4_q[i] <= WW'(num3_q[MW-1:26] * dm3_q[i]);
        lo5_q[i] <= lo4_q[i] + (hi4_q[i] << 26);
        prod6_q[i] <= lo5_q[i];
      end
      p4_q <= p3_q; p5_q <= p4_q; p6_q <= p5_q;
      neg4_q <= neg3_q; neg5_q <= neg4_q; neg6_q <= neg5_q;
      den4_q <= den3_q; den5_q <= den4_q; den6_q <= den5_q;
    end
  end

  // Restoring divider: one quotient bit per stage, three lanes.
  logic dv_q [1:DIVN];
  logic [WW-1:0] rem_q [1:DIVN][3];
  logic [WW-1:0] num_q [1:DIVN][3];
  logic [MW-1:0] dd_q [1:DIVN];
  logic signed [CW-1:0] pp_q [1:DIVN][3];
  logic [2:0] ng_q [1:DIVN];
  for (genvar s = 0; s < DIVN; s++) begin : g_div
    logic v_in;
    logic [WW-1:0] rem_in [3];
    logic [WW-1:0] num_in [3];
    logic [MW-1:0] dd_in;
    logic signed [CW-1:0] pp_in [3];
    logic [2:0] ng_in;
    logic [WW-1:0] sh [3];
    if (s == 0) begin : g_first
      always_comb begin
        v_in = v6_q;
        dd_in = den6_q;
        ng_in = neg6_q;
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = '0;
          num_in[i] = prod6_q[i];
          pp_in[i] = p6_q[i];
        end
      end
    end else begin : g_next
      always_comb begin
        v_in = dv_q[s];
        dd_in = dd_q[s];
        ng_in = ng_q[s];
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = rem_q[s][i];
          num_in[i] = num_q[s][i];
          pp_in[i] = pp_q[s][i];
        end
      end
    end
    always_comb begin
      for (int i = 0; i < 3; i++) sh[i] = {rem_in[i][WW-2:0], num_in[i][WW-1]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[s+1] <= 1'b0;
      else if (adv) dv_q[s+1] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[s+1] <= dd_in;
        ng_q[s+1] <= ng_in;
        for (int i = 0; i < 3; i++) begin
          pp_q[s+1][i] <= pp_in[i];
          if (sh[i] >= WW'(dd_in)) begin
            rem_q[s+1][i] <= sh[i] - WW'(dd_in);
            num_q[s+1][i] <= {num_in[i][WW-2:0], 1'b1};
          end else begin
            rem_q[s+1][i] <= sh[i];
            num_q[s+1][i] <= {num_in[i][WW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Final stage: clamp, sign, add and saturate into the output register.
  logic signed [44:0] sum_f [3];
  logic [QW-1:0] off_f [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_f[i] = (num_q[DIVN][i] > WW'(64'd1 << 40)) ? QW'(64'd1 << 40)
                 : QW'(num_q[DIVN][i]);
      sum_f[i] = 45'(pp_q[DIVN][i]) +
                 (ng_q[DIVN][i] ? -45'(off_f[i]) : 45'(off_f[i]));
    end
  end
  logic ov_q;
  meps_pkg::hit_t hd_q;
  logic signed [CW-1:0] sat_f [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sum_f[i] > 45'sd2147483647) sat_f[i] = 32'sh7fffffff;
      else if (sum_f[i] < -45'sd2147483648) sat_f[i] = 32'sh80000000;
      else sat_f[i] = CW'(sum_f[i]);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= dv_q[DIVN];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hd_q.hit_x <= sat_f[0];
      hd_q.hit_y <= sat_f[1];
      hd_q.hit_z <= sat_f[2];
    end
  end
  assign hit_out.valid = ov_q;
  assign hit_out.data = hd_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_out.valid && !hit_out.ready |=> hit_out.valid && $stable(hit_out.data))
    else $error("hit changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_in.ready == (!hit_out.valid || hit_out.ready))
    else $error("input ready mismatch");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v3_q) && $stable(dv_q[DIVN]))
    else $error("pipeline moved while stalled");
`endif
endmodule
